### rtl/core/qpe_pkg.sv
// Package for the quoted-printable encoder.
// Character constants, register map, segment type and the character tables.
// No dependencies.
package qpe_pkg;

  // Characters
  localparam logic [7:0] CH_EQUALS     = 8'd61;
  localparam logic [7:0] CH_QUESTION   = 8'd63;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_BANG       = 8'd33;
  localparam logic [7:0] CH_TILDE      = 8'd126;

  // Line limit cap and reset value
  localparam logic [6:0] LINE_LIMIT_CAP = 7'd74;
  localparam logic [6:0] COL_MAX        = 7'd127;

  // Escape and literal lengths in characters
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_LIT  = 2'd1;
  localparam logic [1:0] LEN_ESC  = 2'd3;

  // Register map (index = paddr[3:2])
  typedef enum logic [1:0] {
    REG_Q_HEADER_MODE   = 2'd0,
    REG_TEXT_MODE       = 2'd1,
    REG_CUT_LINES       = 2'd2,
    REG_MAX_LINE_LENGTH = 2'd3
  } reg_idx_t;

  // One piece of output: up to three characters, chars[0] goes first
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      len;
  } seg_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'd48 + {4'd0, nib};
    end else begin
      ch = 8'd55 + {4'd0, nib};
    end
    return ch;
  endfunction

  // RFC 2047 Q characters that pass literally
  function automatic logic q_literal(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
         (c >= 8'd97 && c <= 8'd122) || c == 8'd33 || c == 8'd42 ||
         c == 8'd43 || c == 8'd45 || c == 8'd47;
    return ok;
  endfunction

  // Segments for an escape, a literal and a soft break
  function automatic seg_t seg_hex(input logic [7:0] c);
    seg_t s;
    s.chars = {hex_char(c[3:0]), hex_char(c[7:4]), CH_EQUALS};
    s.len   = LEN_ESC;
    return s;
  endfunction

  function automatic seg_t seg_lit(input logic [7:0] c);
    seg_t s;
    s.chars = {8'd0, 8'd0, c};
    s.len   = LEN_LIT;
    return s;
  endfunction

  function automatic seg_t seg_break();
    seg_t s;
    s.chars = {CH_LF, CH_CR, CH_EQUALS};
    s.len   = LEN_ESC;
    return s;
  endfunction

  function automatic seg_t seg_none();
    seg_t s;
    s.chars = '0;
    s.len   = LEN_NONE;
    return s;
  endfunction

  // Column advance, saturating at 127
  function automatic logic [6:0] col_add(input logic [6:0] col, input logic [1:0] k);
    logic [7:0] sum;
    sum = {1'b0, col} + {6'd0, k};
    return sum[7] ? COL_MAX : sum[6:0];
  endfunction

endpackage

### rtl/core/qpe_in_if.sv
// Input channel of the quoted-printable encoder: one raw octet per beat.
// No dependencies.
interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

### rtl/core/qpe_out_if.sv
// Output channel of the quoted-printable encoder: one encoded character per beat.
// No dependencies.
interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;

  modport source (output valid, out_char, run_end, input ready);
  modport sink   (input valid, out_char, run_end, output ready);
endinterface

### rtl/core/quoted_printable_encoder.sv
// Quoted-printable encoder top level (RFC 2045 body, RFC 2047 Q header).
// Depends on qpe_pkg, qpe_in_if and qpe_out_if.
//
// Each input beat carries one octet; the block answers with its encoded text one
// character per output beat, run_end marking the last character of the item. The
// whole encoding of an octet (held space, soft breaks, escape or literal) is worked
// out in the cycle the beat is accepted and parked in an output buffer of up to
// twelve characters, which then drains one character per cycle while out_ch.ready
// is high. An item has 1 character for a literal, 3 for an escape and up to 12 with
// a held space and two soft breaks; an item that yields nothing (a held space) puts
// out no beat. The next beat is accepted in the same cycle the last character of
// the previous one is taken. Configuration is to be written over the APB port only
// while no item is in flight; the user is bound by this, the block does not enforce it.
module quoted_printable_encoder
  import qpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  qpe_in_if.sink      in_ch,
  qpe_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic       q_header_mode;
  logic       text_mode;
  logic       cut_lines;
  logic [6:0] max_line_length;

  // Encoder state
  logic [6:0] column;
  logic       space_pending;

  // Output buffer
  seg_t       segs [4];
  logic [1:0] seg_idx;
  logic [1:0] pos;
  logic       busy;

  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  logic       in_fire;
  logic       out_fire;

  // APB port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_header_mode   <= 1'b0;
      text_mode       <= 1'b0;
      cut_lines       <= 1'b0;
      max_line_length <= LINE_LIMIT_CAP;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_Q_HEADER_MODE:   q_header_mode   <= pwdata[0];
        REG_TEXT_MODE:       text_mode       <= pwdata[0];
        REG_CUT_LINES:       cut_lines       <= pwdata[0];
        REG_MAX_LINE_LENGTH: max_line_length <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_Q_HEADER_MODE:   prdata = {31'd0, q_header_mode};
      REG_TEXT_MODE:       prdata = {31'd0, text_mode};
      REG_CUT_LINES:       prdata = {31'd0, cut_lines};
      REG_MAX_LINE_LENGTH: prdata = {25'd0, max_line_length};
      default:             prdata = '0;
    endcase
  end

  // Encode one octet into four segments
  logic [7:0] c;
  logic       fin;
  logic [6:0] limit;
  logic [7:0] brk_at;
  logic       brk_en;
  logic       is_crlf;
  logic [6:0] col_a, col_b, col_c, col_d;
  logic       brk1, brk2, check;
  logic       pend_next;
  seg_t       new_segs [4];

  always_comb begin
    c       = in_ch.data_byte;
    fin     = in_ch.final_byte;
    limit   = (max_line_length > LINE_LIMIT_CAP) ? LINE_LIMIT_CAP : max_line_length;
    brk_en  = cut_lines && !q_header_mode && (limit != 7'd0);
    brk_at  = {1'b0, limit} - 8'd1;
    is_crlf = (c == CH_CR) || (c == CH_LF);

    // held space
    new_segs[0] = seg_none();
    col_a       = column;
    if (space_pending) begin
      if (q_header_mode) begin
        new_segs[0] = seg_lit(CH_UNDERSCORE);
      end else if (is_crlf) begin
        new_segs[0] = seg_hex(CH_SPACE);
      end else begin
        new_segs[0] = seg_lit(CH_SPACE);
      end
      col_a = col_add(column, new_segs[0].len);
    end
    brk1        = space_pending && brk_en && ({1'b0, col_a} >= brk_at);
    new_segs[1] = brk1 ? seg_break() : seg_none();
    col_b       = brk1 ? 7'd0 : col_a;

    // the octet itself
    check     = 1'b1;
    pend_next = 1'b0;
    if (q_header_mode) begin
      if (c == CH_SPACE) begin
        new_segs[2] = seg_lit(CH_UNDERSCORE);
      end else if (q_literal(c)) begin
        new_segs[2] = seg_lit(c);
      end else begin
        new_segs[2] = seg_hex(c);
      end
    end else if (c == CH_DOT && col_b == 7'd0) begin
      new_segs[2] = seg_hex(c);
      check       = 1'b0;
    end else if (c == CH_SPACE) begin
      if (fin) begin
        new_segs[2] = seg_hex(c);
      end else begin
        new_segs[2] = seg_none();
        check       = 1'b0;
        pend_next   = 1'b1;
      end
    end else if (c == CH_TAB || c == CH_EQUALS) begin
      new_segs[2] = seg_hex(c);
    end else if (is_crlf) begin
      new_segs[2] = text_mode ? seg_lit(c) : seg_hex(c);
    end else if (c >= CH_BANG && c <= CH_TILDE && c != CH_QUESTION) begin
      new_segs[2] = seg_lit(c);
    end else begin
      new_segs[2] = seg_hex(c);
    end
    col_c       = col_add(col_b, new_segs[2].len);
    brk2        = check && brk_en && ({1'b0, col_c} >= brk_at);
    new_segs[3] = brk2 ? seg_break() : seg_none();
    col_d       = brk2 ? 7'd0 : col_c;
  end

  // First non-empty segment of a freshly encoded item
  logic       ld_found;
  logic [1:0] ld_idx;

  always_comb begin
    ld_found = 1'b0;
    ld_idx   = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (new_segs[i].len != LEN_NONE) begin
        ld_found = 1'b1;
        ld_idx   = 2'(i);
      end
    end
  end

  // Drain position: end of segment and next non-empty segment
  logic       seg_last;
  logic       nxt_found;
  logic [1:0] nxt_idx;
  logic       run_end;

  always_comb begin
    seg_last  = (pos == segs[seg_idx].len - 2'd1);
    nxt_found = 1'b0;
    nxt_idx   = seg_idx;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > seg_idx && segs[i].len != LEN_NONE) begin
        nxt_found = 1'b1;
        nxt_idx   = 2'(i);
      end
    end
    run_end = seg_last && !nxt_found;
  end

  // Handshakes
  assign out_fire        = busy && out_ch.ready;
  assign in_ch.ready     = !busy || (out_fire && run_end);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = busy;
  assign out_ch.out_char = segs[seg_idx].chars[pos];
  assign out_ch.run_end  = run_end;

  // Encoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= 7'd0;
      space_pending <= 1'b0;
    end else if (in_fire) begin
      column        <= col_d;
      space_pending <= pend_next;
    end
  end

  // Buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      seg_idx <= 2'd0;
      pos     <= 2'd0;
    end else if (in_fire) begin
      busy    <= ld_found;
      seg_idx <= ld_idx;
      pos     <= 2'd0;
    end else if (out_fire) begin
      if (!seg_last) begin
        pos <= pos + 2'd1;
      end else if (nxt_found) begin
        seg_idx <= nxt_idx;
        pos     <= 2'd0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // Buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) begin
        segs[i] <= new_segs[i];
      end
    end
  end

endmodule

### tb/qpe_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the quoted-printable encoder: watches the APB port and both channels,
// predicts the encoded text of every accepted octet and compares it character by character.
// Depends on qpe_pkg, qpe_in_if and qpe_out_if.
module qpe_checker
  import qpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  qpe_in_if           in_ch,
  qpe_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          pending_chars
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } qp_char_t;

  // Expected characters, oldest first
  qp_char_t expected_text[$];

  // Shadow of the registers
  logic       q_mode;
  logic       crlf_literal;
  logic       cut_on;
  logic [6:0] line_limit;

  // Shadow of the encoder state
  logic [6:0] col;
  logic       space_held;

  // Characters of the octet being predicted
  qp_char_t   run_buf [12];
  int         run_len;

  int fails = 0;
  int waiting = 0;

  assign mismatch_count = fails;
  assign pending_chars  = waiting;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'd48 + {4'd0, nib} : 8'd55 + {4'd0, nib};
  endfunction

  // RFC 2047 Q characters that go out as they are
  function automatic logic is_q_safe(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "!" || c == "*" || c == "+" || c == "-" || c == "/";
  endfunction

  task automatic emit_char(input logic [7:0] ch);
    if (run_len < 12) begin
      run_buf[run_len] = '{ch: ch, last: 1'b0};
      run_len++;
    end
  endtask

  // Column moves on and sticks at 127
  task automatic advance_col(input int k);
    int s;
    s = col + k;
    col = (s > 127) ? 7'd127 : s[6:0];
  endtask

  task automatic emit_lit(input logic [7:0] ch);
    emit_char(ch);
    advance_col(1);
  endtask

  task automatic emit_esc(input logic [7:0] ch);
    emit_char(CH_EQUALS);
    emit_char(hex_digit(ch[7:4]));
    emit_char(hex_digit(ch[3:0]));
    advance_col(3);
  endtask

  // Soft line break once the column reaches limit-1; limits above 74 count as 74
  task automatic try_break();
    int lim;
    lim = (line_limit > 7'd74) ? 74 : line_limit;
    if (cut_on && lim != 0 && col >= lim - 1) begin
      emit_char(CH_EQUALS);
      emit_char(CH_CR);
      emit_char(CH_LF);
      col = '0;
    end
  endtask

  // Encoded text for one input octet, appended to the expected text
  task automatic encode_octet(input logic [7:0] c, input logic fin);
    logic check;
    check = 1'b1;
    run_len = 0;

    // A held space resolves before the new octet
    if (space_held) begin
      space_held = 1'b0;
      if (q_mode) begin
        emit_lit("_");
      end else begin
        if (c == CH_CR || c == CH_LF) emit_esc(CH_SPACE);
        else emit_lit(CH_SPACE);
        try_break();
      end
    end

    if (q_mode) begin
      if (c == CH_SPACE) emit_lit("_");
      else if (is_q_safe(c)) emit_lit(c);
      else emit_esc(c);
    end else if (c == CH_DOT && col == 7'd0) begin
      // dot at line start: escaped, no break check
      emit_esc(c);
    end else begin
      if (c == CH_SPACE) begin
        if (fin) begin
          emit_esc(c);
        end else begin
          space_held = 1'b1;
          check = 1'b0;
        end
      end else if (c == CH_TAB || c == CH_EQUALS) begin
        emit_esc(c);
      end else if (c == CH_CR || c == CH_LF) begin
        if (crlf_literal) emit_lit(c);
        else emit_esc(c);
      end else if (c >= 8'd33 && c <= 8'd126 && c != CH_QUESTION) begin
        emit_lit(c);
      end else begin
        emit_esc(c);
      end
      if (check) try_break();
    end

    for (int i = 0; i < run_len; i++) begin
      if (i == run_len - 1) run_buf[i].last = 1'b1;
      expected_text = {expected_text, run_buf[i]};
    end
  endtask

  // Monitor: register writes, input beats, output beats
  always @(posedge clk) begin
    if (rst) begin
      q_mode       = 1'b0;
      crlf_literal = 1'b0;
      cut_on       = 1'b0;
      line_limit   = 7'd74;
      col          = '0;
      space_held   = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_Q_HEADER_MODE:   q_mode       = pwdata[0];
          REG_TEXT_MODE:       crlf_literal = pwdata[0];
          REG_CUT_LINES:       cut_on       = pwdata[0];
          REG_MAX_LINE_LENGTH: line_limit   = pwdata[6:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) encode_octet(in_ch.data_byte, in_ch.final_byte);

      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          if (fails < 10)
            $display("mismatch: char %02h run_end %0b with nothing expected",
                     out_ch.out_char, out_ch.run_end);
          fails++;
        end else begin
          qp_char_t want;
          want = expected_text.pop_front();
          if (want.ch !== out_ch.out_char || want.last !== out_ch.run_end) begin
            if (fails < 10)
              $display("mismatch: expected char %02h run_end %0b, got char %02h run_end %0b",
                       want.ch, want.last, out_ch.out_char, out_ch.run_end);
            fails++;
          end
        end
      end
    end
    waiting = expected_text.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the quoted-printable encoder testbench: clock, reset, APB set-up and octet stimulus.
// Depends on qpe_pkg, qpe_in_if, qpe_out_if, qpe_checker and quoted_printable_encoder.
module tb
  import qpe_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SEGMENTS     = 10;
  localparam int SEG_OCTETS   = 26;

  // Settings of the random segments, segment 0 in bit 0
  localparam logic [SEGMENTS-1:0] SEG_Q   = 10'b0001000100;
  localparam logic [SEGMENTS-1:0] SEG_TXT = 10'b0101101010;
  localparam logic [SEGMENTS-1:0] SEG_CUT = 10'b0111110011;
  localparam logic [SEGMENTS-1:0][6:0] SEG_LIM = {7'd100, 7'd40, 7'd0, 7'd10, 7'd2,
                                                  7'd127, 7'd0, 7'd74, 7'd1, 7'd74};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_chars;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  qpe_in_if  in_ch ();
  qpe_out_if out_ch ();

  quoted_printable_encoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qpe_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending_chars  (pending_chars)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // One octet beat, with random gaps before it
  task automatic send_octet(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and let every expected character come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup and access cycle; the caller releases the bus after the last write
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic q, input logic txt, input logic cut,
                           input logic [6:0] lim);
    drain();
    write_reg(REG_Q_HEADER_MODE, {31'd0, q});
    write_reg(REG_TEXT_MODE, {31'd0, txt});
    write_reg(REG_CUT_LINES, {31'd0, cut});
    write_reg(REG_MAX_LINE_LENGTH, {25'd0, lim});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly text-like octets, with plenty of spaces, line ends and escapes
  function automatic logic [7:0] pick_octet();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 8'($urandom_range(126, 33));
    if (r < 50) return CH_SPACE;
    if (r < 58) return $urandom_range(1) ? CH_CR : CH_LF;
    if (r < 63) return CH_DOT;
    if (r < 70) begin
      case ($urandom_range(3))
        0: return CH_TAB;
        1: return CH_EQUALS;
        2: return CH_QUESTION;
        default: return CH_UNDERSCORE;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 15;
    sink_idle_pct = 71;

    // Directed: reset settings, plain body encoding
    send_octet(CH_DOT, 1'b0);       // dot at line start
    send_octet(CH_DOT, 1'b0);       // dot mid-line
    send_octet(8'h00, 1'b0);
    send_octet(8'hFF, 1'b0);
    send_octet(CH_TAB, 1'b0);
    send_octet(CH_EQUALS, 1'b0);
    send_octet(CH_QUESTION, 1'b0);
    send_octet(8'd33, 1'b0);
    send_octet(8'd126, 1'b0);
    send_octet(8'h7F, 1'b0);
    send_octet(CH_CR, 1'b0);
    send_octet(CH_SPACE, 1'b0);     // held, no output
    send_octet("x", 1'b0);
    send_octet(CH_SPACE, 1'b0);
    send_octet(CH_LF, 1'b0);        // held space before line end
    send_octet(CH_SPACE, 1'b1);     // space at end of data
    send_octet(CH_SPACE, 1'b0);     // left held across the mode change
    // Directed: header mode picks up the held space
    configure(1'b1, 1'b0, 1'b0, 7'd74);
    send_octet("a", 1'b0);
    send_octet(CH_SPACE, 1'b0);
    send_octet(CH_UNDERSCORE, 1'b0);
    send_octet("*", 1'b0);
    // Directed: literal CR/LF, limit 1 with breaks after the line ends and the held space, dot after a break
    configure(1'b0, 1'b1, 1'b1, 7'd1);
    send_octet(CH_CR, 1'b0);
    send_octet(CH_SPACE, 1'b0);
    send_octet(CH_DOT, 1'b0);
    send_octet(CH_LF, 1'b1);

    // Random segments, each under its own settings
    for (int s = 0; s < SEGMENTS; s++) begin
      logic [6:0] lim;
      if (s < 4) begin
        src_idle_pct  = 15;
        sink_idle_pct = 71;
      end else if (s < 7) begin
        src_idle_pct  = 71;
        sink_idle_pct = 15;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      lim = SEG_LIM[s];
      if (s == 8) lim = 7'($urandom_range(74, 3));
      if (s == 9) lim = 7'($urandom_range(127));
      configure(SEG_Q[s], SEG_TXT[s], SEG_CUT[s], lim);
      for (int k = 0; k < SEG_OCTETS; k++) begin
        send_octet(pick_octet(), $urandom_range(9) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_chars == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
